FILE: rtl/kmpd_pkg.sv
`timescale 1ns / 1ps
package kmpd_pkg;

    localparam int SLOTS_DEF         = 8;
    localparam int ID_CHARS_DEF      = 8;
    localparam int PAYLOAD_CHARS_DEF = 64;

    localparam int NAME_CHARS = 2;
    localparam int MASK_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = 6;
    localparam int NAME_W     = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_REG   = 2'd1,
        OP_UNREG = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ID      = 2'd1,
        KIND_NAME    = 2'd2,
        KIND_PAYLOAD = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        MODE_KEY     = 4'b0001,
        MODE_ID      = 4'b0010,
        MODE_NAME    = 4'b0100,
        MODE_PAYLOAD = 4'b1000
    } mode_t;

    // Output tdata layout, last member in the lowest bits.
    typedef struct packed {
        logic [4:0]        pad;
        logic [SLOT_W-1:0] slot;
        logic              op_ok;
        logic [NAME_W-1:0] message_name;
        logic [MASK_W-1:0] match_mask;
        logic              parse_error;
        logic [7:0]        char_out;
        logic [IDX_W-1:0]  field_index;
    } res_data_t;

    typedef struct packed {
        kind_t     kind;
        logic      done;
        res_data_t data;
    } res_t;

endpackage

FILE: rtl/keyed_message_parse_dispatch.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while s_tready is high; all parsing and the
// parallel slot compares are done in one combinational pass ahead of the
// result register. An output register plus a skid register keep s_tready off
// the m_tready path.
// Reset (rst_n low, asynchronous): parser back to key mode, slot table empty,
// no result pending.
module keyed_message_parse_dispatch
    import kmpd_pkg::*;
#(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int ID_CHARS      = ID_CHARS_DEF,
    parameter int PAYLOAD_CHARS = PAYLOAD_CHARS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // data_byte[7:0], name_code[23:8]
    input  logic [1:0]            s_tuser,  // operation[1:0]
    input  logic                  s_tlast,  // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // field_index[5:0], char_out[13:6],
                                            // parse_error[14], match_mask[22:15],
                                            // message_name[38:23], op_ok[39],
                                            // slot[42:40], zero[47:43]
    output logic [1:0]            m_tuser,  // field_kind[1:0]
    output logic                  m_tlast   // message_done
);

    localparam int CNT_MAX0 = (ID_CHARS > PAYLOAD_CHARS) ? ID_CHARS : PAYLOAD_CHARS;
    localparam int CNT_MAX  = (CNT_MAX0 > NAME_CHARS) ? CNT_MAX0 : NAME_CHARS;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    logic [NAME_W-1:0] slots_reg [SLOTS];
    logic [NAME_W-1:0] slots_next [SLOTS];
    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              colon_reg, colon_next;
    logic              aborted_reg, aborted_next;
    logic [NAME_W-1:0] name_reg, name_next;

    res_t res;
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic accept, out_take;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    always_comb
    begin
        logic [7:0]        c;
        logic [NAME_W-1:0] nm;
        logic              found;

        c     = s_tdata[7:0];
        nm    = s_tdata[IN_DATA_W-1:8];
        found = 1'b0;

        slots_next   = slots_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        colon_next   = colon_reg;
        aborted_next = aborted_reg;
        name_next    = name_reg;
        res          = '0;

        unique case (op_t'(s_tuser))
            OP_BYTE:
            begin
                if (!aborted_reg)
                begin
                    if (colon_reg)
                    begin
                        if (c == CH_COLON)
                            colon_next = 1'b0;
                        else
                            aborted_next = 1'b1;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_PAYLOAD:
                            begin
                                if (c == CH_COMMA || count_reg >= CNT_W'(PAYLOAD_CHARS))
                                begin
                                    mode_next  = MODE_KEY;
                                    count_next = '0;
                                end
                                else
                                begin
                                    res.kind             = KIND_PAYLOAD;
                                    res.data.field_index = IDX_W'(count_reg);
                                    res.data.char_out    = c;
                                    count_next           = count_reg + 1'b1;
                                end
                            end
                            MODE_ID:
                            begin
                                if (count_reg >= CNT_W'(ID_CHARS))
                                begin
                                    mode_next  = MODE_KEY;
                                    count_next = '0;
                                end
                                else
                                begin
                                    res.kind             = KIND_ID;
                                    res.data.field_index = IDX_W'(count_reg);
                                    res.data.char_out    = c;
                                    count_next           = count_reg + 1'b1;
                                end
                            end
                            MODE_NAME:
                            begin
                                if (count_reg >= CNT_W'(NAME_CHARS))
                                begin
                                    mode_next  = MODE_KEY;
                                    count_next = '0;
                                end
                                else
                                begin
                                    res.kind             = KIND_NAME;
                                    res.data.field_index = IDX_W'(count_reg);
                                    res.data.char_out    = c;
                                    if (count_reg == '0)
                                        name_next[7:0] = c;
                                    else
                                        name_next[15:8] = c;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            MODE_KEY:
                            begin
                                priority if (c == CH_SPACE || c == CH_COMMA)
                                begin
                                    mode_next = MODE_KEY;
                                end
                                else if (c == CH_I)
                                begin
                                    mode_next  = MODE_ID;
                                    count_next = '0;
                                    colon_next = 1'b1;
                                end
                                else if (c == CH_M)
                                begin
                                    mode_next  = MODE_NAME;
                                    count_next = '0;
                                    colon_next = 1'b1;
                                end
                                else if (c == CH_P)
                                begin
                                    mode_next  = MODE_PAYLOAD;
                                    count_next = '0;
                                    colon_next = 1'b1;
                                end
                                else
                                begin
                                    aborted_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                mode_next  = MODE_KEY;
                                count_next = '0;
                            end
                        endcase
                    end
                end

                res.data.parse_error = aborted_next;
                if (s_tlast)
                begin
                    res.done = 1'b1;
                    if (!aborted_next)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            res.data.match_mask[i] = (slots_reg[i][7:0] != 8'd0)
                                                     && (slots_reg[i] == name_next);
                        res.data.message_name = name_next;
                    end
                    // return the parser to its reset state
                    mode_next    = MODE_KEY;
                    count_next   = '0;
                    colon_next   = 1'b0;
                    aborted_next = 1'b0;
                    name_next    = '0;
                end
            end
            OP_REG:
            begin
                if (nm[7:0] != 8'd0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && (slots_reg[i] == nm || slots_reg[i][7:0] == 8'd0))
                        begin
                            found         = 1'b1;
                            slots_next[i] = nm;
                            res.data.slot = SLOT_W'(i);
                        end
                    end
                    res.data.op_ok = found;
                end
            end
            OP_UNREG:
            begin
                if (nm[7:0] != 8'd0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && slots_reg[i] == nm)
                        begin
                            found         = 1'b1;
                            slots_next[i] = '0;
                            res.data.slot = SLOT_W'(i);
                        end
                    end
                    res.data.op_ok = found;
                end
            end
            OP_NONE:
            begin
                res = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // parser state and slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slots_reg[i] <= '0;
            mode_reg    <= MODE_KEY;
            count_reg   <= '0;
            colon_reg   <= 1'b0;
            aborted_reg <= 1'b0;
            name_reg    <= '0;
        end
        else if (accept)
        begin
            slots_reg   <= slots_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            colon_reg   <= colon_next;
            aborted_reg <= aborted_next;
            name_reg    <= name_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_tready)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.done;

    // A slot operation never captures a character.
    a_op_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.data.op_ok |-> out_reg.kind == KIND_NONE && !out_reg.done)
        else $error("slot operation result carries a captured character");

    // An aborted message reports no dispatch.
    a_abort_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.data.parse_error
            |-> out_reg.data.match_mask == '0 && out_reg.data.message_name == '0)
        else $error("aborted message reports a match");

    // The skid stage only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item ahead of the output register");

    // A colon is only expected inside a field.
    a_colon_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        colon_reg |-> mode_reg != MODE_KEY)
        else $error("colon pending while in key mode");

endmodule

FILE: bench/tb_keyed_message_parse_dispatch.sv
`timescale 1ns / 1ps
module tb_keyed_message_parse_dispatch;
    import kmpd_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 700;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic        last;
        logic [15:0] name;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  idx;
        logic [7:0]  ch;
        logic        done;
        logic        perr;
        logic [7:0]  mask;
        logic [15:0] name;
        logic        ok;
        logic [2:0]  slot;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // Shadow of the parser and the name table
    logic [15:0] name_table [SLOTS_DEF];
    mode_t       cur_mode;
    int          char_count;
    logic        colon_wait;
    logic        dead_msg;
    logic [15:0] seen_name;

    in_item_t    input_items[$];
    result_t     due_results[$];
    logic [7:0]  msg_bytes[$];
    logic [15:0] name_pool [6];
    in_item_t    cur_item;

    res_data_t   got_data;
    result_t     got_res;
    result_t     want_res;

    int cycle_count;
    int items_made;
    int results_checked;
    int mismatch_count;
    int msgs_done;
    int msgs_aborted;
    int msgs_matched;
    int table_updates;

    keyed_message_parse_dispatch u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic bit idle_roll();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    function automatic logic [7:0] pick_sep();
        return $urandom_range(0, 1) ? CH_SPACE : CH_COMMA;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0: return CH_I;
            1: return CH_M;
            2: return CH_P;
            3: return CH_COLON;
            4: return CH_COMMA;
            5: return CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf({"kind=%0d idx=%0d char=%h done=%b err=%b ",
                          "mask=%h name=%h ok=%b slot=%0d"},
                         r.kind, r.idx, r.ch, r.done, r.perr, r.mask, r.name, r.ok, r.slot);
    endfunction

    function automatic void clear_parse();
        cur_mode   = MODE_KEY;
        char_count = 0;
        colon_wait = 1'b0;
        dead_msg   = 1'b0;
        seen_name  = '0;
    endfunction

    // Work out the result of one accepted item and advance the shadow state
    function automatic void parse_step(input in_item_t it);
        result_t    r;
        logic [7:0] c;
        r = '0;
        c = it.data;
        case (it.op)
            OP_BYTE:
            begin
                if (!dead_msg) begin
                    if (colon_wait) begin
                        if (c == CH_COLON)
                            colon_wait = 1'b0;
                        else
                            dead_msg = 1'b1;
                    end else begin
                        case (cur_mode)
                            MODE_PAYLOAD:
                            begin
                                if (c == CH_COMMA || char_count >= PAYLOAD_CHARS_DEF) begin
                                    cur_mode   = MODE_KEY;
                                    char_count = 0;
                                end else begin
                                    r.kind = KIND_PAYLOAD;
                                    r.idx  = char_count[5:0];
                                    r.ch   = c;
                                    char_count++;
                                end
                            end
                            MODE_ID:
                            begin
                                if (char_count >= ID_CHARS_DEF) begin
                                    cur_mode   = MODE_KEY;
                                    char_count = 0;
                                end else begin
                                    r.kind = KIND_ID;
                                    r.idx  = char_count[5:0];
                                    r.ch   = c;
                                    char_count++;
                                end
                            end
                            MODE_NAME:
                            begin
                                if (char_count >= NAME_CHARS) begin
                                    cur_mode   = MODE_KEY;
                                    char_count = 0;
                                end else begin
                                    r.kind = KIND_NAME;
                                    r.idx  = char_count[5:0];
                                    r.ch   = c;
                                    if (char_count == 0)
                                        seen_name[7:0] = c;
                                    else
                                        seen_name[15:8] = c;
                                    char_count++;
                                end
                            end
                            default:
                            begin
                                if (c == CH_SPACE || c == CH_COMMA) begin
                                    // separator, skip
                                end else if (c == CH_I || c == CH_M || c == CH_P) begin
                                    cur_mode   = (c == CH_I) ? MODE_ID :
                                                 (c == CH_M) ? MODE_NAME : MODE_PAYLOAD;
                                    char_count = 0;
                                    colon_wait = 1'b1;
                                end else begin
                                    dead_msg = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                r.perr = dead_msg;
                if (it.last) begin
                    r.done = 1'b1;
                    msgs_done++;
                    if (dead_msg) begin
                        msgs_aborted++;
                    end else begin
                        for (int i = 0; i < SLOTS_DEF; i++)
                            if (name_table[i][7:0] != 8'h00 && name_table[i] == seen_name)
                                r.mask[i] = 1'b1;
                        r.name = seen_name;
                        if (r.mask != '0)
                            msgs_matched++;
                    end
                    clear_parse();
                end
            end
            OP_REG:
            begin
                if (it.name[7:0] != 8'h00) begin
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (name_table[i] == it.name || name_table[i][7:0] == 8'h00) begin
                            name_table[i] = it.name;
                            r.ok   = 1'b1;
                            r.slot = i[2:0];
                            break;
                        end
                    end
                end
            end
            OP_UNREG:
            begin
                if (it.name[7:0] != 8'h00) begin
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (name_table[i] == it.name) begin
                            name_table[i] = '0;
                            r.ok   = 1'b1;
                            r.slot = i[2:0];
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (r.ok)
            table_updates++;
        due_results.push_back(r);
    endfunction

    task automatic add_item(input op_t op, input logic [7:0] data, input logic last,
                            input logic [15:0] name);
        in_item_t it;
        it.op   = op;
        it.data = data;
        it.last = last;
        it.name = name;
        input_items.push_back(it);
        items_made++;
    endtask

    // Send the bytes gathered in msg_bytes as one message
    task automatic flush_message();
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
            add_item(OP_BYTE, msg_bytes[i], i == n - 1, 16'($urandom_range(0, 65535)));
        msg_bytes.delete();
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Item driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_step(cur_item);
            if (!s_tvalid || s_tready) begin
                if (input_items.size() != 0 && !idle_roll()) begin
                    cur_item = input_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.name, cur_item.data};
                    s_tuser  <= cur_item.op;
                    s_tlast  <= cur_item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_data     = m_tdata;
                got_res      = '0;
                got_res.kind = kind_t'(m_tuser);
                got_res.idx  = got_data.field_index;
                got_res.ch   = got_data.char_out;
                got_res.done = m_tlast;
                got_res.perr = got_data.parse_error;
                got_res.mask = got_data.match_mask;
                got_res.name = got_data.message_name;
                got_res.ok   = got_data.op_ok;
                got_res.slot = got_data.slot;
                results_checked++;
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result at cycle %0d: %s",
                                 cycle_count, fmt_result(got_res));
                end else begin
                    want_res = due_results.pop_front();
                    if (got_res !== want_res) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("mismatch on result %0d at cycle %0d",
                                     results_checked, cycle_count);
                            $display("  expected %s", fmt_result(want_res));
                            $display("  actual   %s", fmt_result(got_res));
                        end
                    end
                end
            end
            m_tready <= !idle_roll();
        end
    end

    initial begin
        int          roll;
        int          nf;
        int          len;
        int          pos;
        logic [7:0]  b;
        logic [15:0] nm;
        logic [15:0] last_random_name;

        for (int i = 0; i < SLOTS_DEF; i++)
            name_table[i] = '0;
        clear_parse();
        name_pool[0] = 16'h6261;    // "ab"
        name_pool[1] = 16'h6463;    // "cd"
        name_pool[2] = 16'h7978;    // "xy"
        name_pool[3] = 16'h0071;    // "q" with an empty second char
        name_pool[4] = 16'hFFFF;
        name_pool[5] = 16'h0101;
        last_random_name = 16'h5A5A;

        // Table ops: empty name, repeat register, extremes, unknown unregister
        add_item(OP_REG,   8'h00, 1'b0, 16'h0000);
        add_item(OP_REG,   8'hFF, 1'b1, 16'h6261);
        add_item(OP_REG,   8'h00, 1'b0, 16'h6261);
        add_item(OP_REG,   8'h00, 1'b0, 16'hFFFF);
        add_item(OP_UNREG, 8'h00, 1'b0, 16'hFF00);
        add_item(OP_UNREG, 8'h00, 1'b0, 16'h1234);
        add_item(OP_NONE,  8'hFF, 1'b1, 16'hFFFF);
        // Name field ended by a byte after two chars, then payload
        msg_bytes = '{CH_M, CH_COLON, 8'h61, 8'h62, CH_SPACE, CH_P, CH_COLON, 8'h78};
        flush_message();
        // Unknown key, then ignored bytes
        msg_bytes = '{8'h7A, CH_M, 8'hFF};
        flush_message();
        // Missing colon after a key
        msg_bytes = '{CH_I, 8'h78};
        flush_message();
        // Empty name must not hit the freed slot
        add_item(OP_UNREG, 8'h00, 1'b0, 16'h6261);
        msg_bytes = '{CH_COMMA};
        flush_message();

        while (items_made < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 18) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: nm = name_pool[$urandom_range(0, 5)];
                    6, 7: nm = 16'($urandom_range(0, 65535));
                    8: nm = last_random_name;
                    default: nm = {8'($urandom_range(0, 255)), 8'h00};
                endcase
                if ($urandom_range(0, 1)) begin
                    if (nm != last_random_name && $urandom_range(0, 2) == 0)
                        last_random_name = nm;
                    add_item(OP_REG, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), nm);
                end else begin
                    add_item(OP_UNREG, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             nm);
                end
            end else if (roll < 22) begin
                add_item(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
            end else if (roll < 32) begin
                repeat ($urandom_range(1, 5))
                    msg_bytes.push_back(pick_char());
                flush_message();
            end else begin
                nf = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    msg_bytes.push_back(pick_sep());
                for (int f = 0; f < nf; f++) begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            msg_bytes.push_back(CH_I);
                            msg_bytes.push_back(CH_COLON);
                            repeat (ID_CHARS_DEF + 1)
                                msg_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        1:
                        begin
                            nm = ($urandom_range(0, 4) != 0) ? name_pool[$urandom_range(0, 5)]
                                                              : 16'($urandom_range(0, 65535));
                            msg_bytes.push_back(CH_M);
                            msg_bytes.push_back(CH_COLON);
                            msg_bytes.push_back(nm[7:0]);
                            msg_bytes.push_back(nm[15:8]);
                            msg_bytes.push_back($urandom_range(0, 1) ? pick_sep()
                                                                     : 8'($urandom_range(0, 255)));
                        end
                        default:
                        begin
                            len = ($urandom_range(0, 15) == 0) ? PAYLOAD_CHARS_DEF
                                                               : $urandom_range(0, 10);
                            msg_bytes.push_back(CH_P);
                            msg_bytes.push_back(CH_COLON);
                            repeat (len) begin
                                b = 8'($urandom_range(0, 255));
                                msg_bytes.push_back(b == CH_COMMA ? 8'h2D : b);
                            end
                            // a full payload drops the next byte instead of a comma
                            msg_bytes.push_back(len == PAYLOAD_CHARS_DEF ?
                                                8'($urandom_range(0, 255)) : CH_COMMA);
                        end
                    endcase
                    repeat ($urandom_range(0, 2))
                        msg_bytes.push_back(pick_sep());
                end
                if (msg_bytes.size() == 0)
                    msg_bytes.push_back(pick_sep());
                if ($urandom_range(0, 6) == 0) begin
                    pos = $urandom_range(0, msg_bytes.size() - 1);
                    if ($urandom_range(0, 1))
                        msg_bytes[pos] = pick_char();
                    else
                        while (msg_bytes.size() > pos + 1)
                            void'(msg_bytes.pop_back());
                end
                flush_message();
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (input_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        mismatch_count += due_results.size();

        $display("%0d items: %0d messages (%0d aborted, %0d hit a slot), %0d table updates",
                 items_made, msgs_done, msgs_aborted, msgs_matched, table_updates);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
